FILE: rtl/core/bsc_pkg.sv
// Shared types, constants and helpers for the barometric sensor compensation block.
package bsc_pkg;

  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 64;

  localparam logic [CFG_IDX_W-1:0] REG_TEMP      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PRESS_LO  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PRESS_HI  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_PRESS_HUM = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_HUM_OFS   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_HUM_EN    = 3'd5;

  localparam logic [19:0] RAW_OFF20 = 20'h80000;
  localparam logic [15:0] RAW_OFF16 = 16'h8000;

  localparam logic [31:0] K_64000   = 32'd64000;
  localparam logic [31:0] K_1048576 = 32'd1048576;
  localparam logic [31:0] K_3125    = 32'd3125;
  localparam logic [31:0] K_32768   = 32'd32768;
  localparam logic [31:0] K_76800   = 32'd76800;
  localparam logic [31:0] K_2097152 = 32'd2097152;
  localparam logic [31:0] K_8192    = 32'd8192;
  localparam logic [31:0] K_16384   = 32'd16384;
  localparam logic [31:0] K_128     = 32'd128;
  localparam logic [31:0] K_1000    = 32'd1000;
  localparam logic [31:0] HUM_MAX   = 32'd419430400;
  localparam logic [31:0] MM_DIV    = 32'd13333;
  // floor(2^45 / 13333); quotient estimate is low by at most one
  localparam logic [31:0] MM_RECIP  = 32'd2638893879;

  typedef struct packed {
    logic [31:0] t1, t2, t3;
    logic [31:0] p1, p2, p3, p4, p5, p6, p7, p8, p9;
    logic [31:0] h1, h2, h3, h4, h5, h6;
    logic        hum_en;
  } coef_t;

  typedef struct packed {
    logic [31:0] ta;
    logic [31:0] tb;
    logic [19:0] adc_p;
    logic [15:0] adc_h;
    logic        tv;
    logic        pv;
    logic        hv;
  } item_t;

  function automatic logic [31:0] asr(input logic [31:0] x, input int unsigned n);
    asr = $unsigned($signed(x) >>> n);
  endfunction

endpackage

FILE: rtl/core/bsc_front.sv
// Input stage: takes raw reading beats, flags disabled channels, forms temperature deltas.
module bsc_front import bsc_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [19:0] raw_temperature,
  input  logic [19:0] raw_pressure,
  input  logic [15:0] raw_humidity,
  input  coef_t       coef,
  input  logic        push_ok,
  output logic        fv,
  output item_t       fitem
);

  logic tv;

  assign in_ready = !fv || push_ok;
  assign tv = (raw_temperature != RAW_OFF20);

  always_ff @(posedge clk) begin
    if (rst) begin
      fv <= 1'b0;
    end else if (in_valid && in_ready) begin
      fv <= 1'b1;
    end else if (push_ok) begin
      fv <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      fitem.ta    <= ({12'b0, raw_temperature} >> 3) - (coef.t1 << 1);
      fitem.tb    <= ({12'b0, raw_temperature} >> 4) - coef.t1;
      fitem.adc_p <= raw_pressure;
      fitem.adc_h <= raw_humidity;
      fitem.tv    <= tv;
      fitem.pv    <= tv && (raw_pressure != RAW_OFF20);
      fitem.hv    <= tv && coef.hum_en && (raw_humidity != RAW_OFF16);
    end
  end

endmodule

FILE: rtl/core/bsc_fifo.sv
// Short queue of classified beats between front and back.
module bsc_fifo import bsc_pkg::*; #(
  parameter int DEPTH = 4
) (
  input  logic  clk,
  input  logic  rst,
  input  logic  push,
  input  item_t push_item,
  output logic  full,
  input  logic  pop,
  output logic  q_valid,
  output item_t q_item
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);

  item_t         mem [DEPTH];
  logic [AW-1:0] wr_ptr, rd_ptr;
  logic [CW-1:0] cnt;

  assign full    = (cnt == CW'(DEPTH));
  assign q_valid = (cnt != '0);
  assign q_item  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      cnt    <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == LAST) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == LAST) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        cnt <= cnt + 1'b1;
      end else if (pop && !push) begin
        cnt <= cnt - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_item;
    end
  end

endmodule

FILE: rtl/core/bsc_div.sv
// Pipelined 32-bit unsigned restoring divider, one quotient bit per stage.
module bsc_div #(
  parameter int SIDE_W = 1
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              en,
  input  logic              in_valid,
  input  logic [31:0]       dividend,
  input  logic [31:0]       divisor,
  input  logic [SIDE_W-1:0] side_in,
  output logic              out_valid,
  output logic [31:0]       quotient,
  output logic [SIDE_W-1:0] side_out
);

  logic [31:0]       rem_q [1:32];
  logic [31:0]       num_q [1:32];
  logic [31:0]       dvs_q [1:32];
  logic [SIDE_W-1:0] sd_q  [1:32];
  logic [32:1]       vl;

  for (genvar k = 0; k < 32; k++) begin : g_stage
    logic [31:0]       r_in, n_in, d_in;
    logic [SIDE_W-1:0] s_in;
    logic              v_in;
    logic [32:0]       trial, diff;
    logic              ge;

    if (k == 0) begin : g_first
      assign r_in = '0;
      assign n_in = dividend;
      assign d_in = divisor;
      assign s_in = side_in;
      assign v_in = in_valid;
    end else begin : g_next
      assign r_in = rem_q[k];
      assign n_in = num_q[k];
      assign d_in = dvs_q[k];
      assign s_in = sd_q[k];
      assign v_in = vl[k];
    end

    assign trial = {r_in, n_in[31]};
    assign diff  = trial - {1'b0, d_in};
    assign ge    = (trial >= {1'b0, d_in});

    always_ff @(posedge clk) begin
      if (rst) begin
        vl[k+1] <= 1'b0;
      end else if (en) begin
        vl[k+1] <= v_in;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_q[k+1] <= ge ? diff[31:0] : trial[31:0];
        num_q[k+1] <= {n_in[30:0], ge};
        dvs_q[k+1] <= d_in;
        sd_q[k+1]  <= s_in;
      end
    end
  end

  assign out_valid = vl[32];
  assign quotient  = num_q[32];
  assign side_out  = sd_q[32];

endmodule

FILE: rtl/core/bsc_back.sv
// Compensation datapath: temperature, pressure, humidity, and the output register.
module bsc_back import bsc_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  coef_t       coef,
  input  logic        q_valid,
  input  item_t       q_item,
  output logic        pop,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [15:0] temperature_c100,
  output logic        temperature_valid,
  output logic [31:0] pressure_pa,
  output logic [31:0] pressure_mmhg10,
  output logic        pressure_valid,
  output logic [9:0]  humidity_h10,
  output logic        humidity_valid
);

  typedef struct packed {
    logic        tv;
    logic        pv;
    logic        hv;
    logic        dz;
    logic [15:0] temp;
  } tag_t;

  typedef struct packed {
    tag_t        tag;
    logic        shf;
    logic [31:0] hx;
  } dside_t;

  logic adv;
  logic [9:1] vpre;
  logic [9:1] vpost;

  // front half
  logic [2:0]  fl1, fl2, fl3, fl4, fl5, fl6, fl7, fl8, fl9;
  logic [19:0] ap1, ap2, ap3, ap4, ap5, ap6, ap7;
  logic [15:0] ah1, ah2, ah3, ah4, ah5;
  logic [15:0] tp4, tp5, tp6, tp7, tp8, tp9;
  logic [31:0] a1, bb1, a2, b2, tf3, tf5x, tsc;
  logic [31:0] v14, q4, hv4;
  logic [31:0] qq5, v1p5_5, p2v1_5, h5v5, vh6_5, vh3_5;
  logic [31:0] v2a6, c6, v1p5_6, p2v1_6, x6, y1_6;
  logic [31:0] v2_7, v1b7, y2_7, x7;
  logic [31:0] v1c8, pnp8, y8, x8;
  logic [31:0] v1d9, pn9, hx9;

  // divider
  dside_t      din_side, dout_side;
  logic        dout_v;
  logic [31:0] quo;

  // back half
  tag_t        tg1, tg2, tg3, tg4, tg5, tg6, tg7, tg8;
  logic [31:0] pd1, pd2, pd3, s1h, hx1, hx2, hx3;
  logic [31:0] pp2, pv8_2, ss2;
  logic [31:0] pv1_3, pv2_3, ht3;
  logic [31:0] pf4, hc4, pf5, pf6, pf7, pf8;
  logic [31:0] m5, m6, m7, r8;
  logic [63:0] prod6;
  logic [9:0]  hm5, hm6, hm7, hm8;
  logic [18:0] q7, q8;
  logic [31:0] hraw, hcl;
  logic [20:0] hmul;
  logic        pok;

  assign adv       = !vpost[9] || out_ready;
  assign pop       = adv && q_valid;
  assign out_valid = vpost[9];

  assign tf5x = (tf3 << 2) + tf3 + K_128;
  assign tsc  = asr(tf5x, 8);

  assign din_side.tag.tv   = fl9[2];
  assign din_side.tag.pv   = fl9[1];
  assign din_side.tag.hv   = fl9[0];
  assign din_side.tag.dz   = (v1d9 == '0);
  assign din_side.tag.temp = tp9;
  assign din_side.shf      = pn9[31];
  assign din_side.hx       = hx9;

  bsc_div #(
    .SIDE_W ($bits(dside_t))
  ) u_div (
    .clk       (clk),
    .rst       (rst),
    .en        (adv),
    .in_valid  (vpre[9]),
    .dividend  (pn9[31] ? pn9 : (pn9 << 1)),
    .divisor   (v1d9),
    .side_in   (din_side),
    .out_valid (dout_v),
    .quotient  (quo),
    .side_out  (dout_side)
  );

  assign hraw = hx3 - asr(ht3, 4);
  assign hcl  = hraw[31] ? '0 : ((hraw > HUM_MAX) ? HUM_MAX : hraw);
  assign hmul = {4'b0, hc4[28:12]} * 21'd10;
  assign pok  = tg8.pv && !tg8.dz;

  always_ff @(posedge clk) begin
    if (rst) begin
      vpre  <= '0;
      vpost <= '0;
    end else if (adv) begin
      vpre  <= {vpre[8:1], q_valid};
      vpost <= {vpost[8:1], dout_v};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      // temperature
      fl1 <= {q_item.tv, q_item.pv, q_item.hv};
      ap1 <= q_item.adc_p;
      ah1 <= q_item.adc_h;
      a1  <= q_item.ta * coef.t2;
      bb1 <= q_item.tb * q_item.tb;

      fl2 <= fl1; ap2 <= ap1; ah2 <= ah1;
      a2  <= asr(a1, 11);
      b2  <= asr(bb1, 12) * coef.t3;

      fl3 <= fl2; ap3 <= ap2; ah3 <= ah2;
      tf3 <= a2 + asr(b2, 14);

      fl4 <= fl3; ap4 <= ap3; ah4 <= ah3;
      tp4 <= tsc[15:0];
      v14 <= asr(tf3, 1) - K_64000;
      q4  <= asr(asr(tf3, 1) - K_64000, 2);
      hv4 <= tf3 - K_76800;

      // pressure and humidity products
      fl5 <= fl4; ap5 <= ap4; ah5 <= ah4; tp5 <= tp4;
      qq5    <= q4 * q4;
      v1p5_5 <= v14 * coef.p5;
      p2v1_5 <= coef.p2 * v14;
      h5v5   <= coef.h5 * hv4;
      vh6_5  <= hv4 * coef.h6;
      vh3_5  <= hv4 * coef.h3;

      fl6 <= fl5; ap6 <= ap5; tp6 <= tp5;
      v2a6   <= asr(qq5, 11) * coef.p6;
      c6     <= asr(qq5, 13) * coef.p3;
      v1p5_6 <= v1p5_5;
      p2v1_6 <= p2v1_5;
      x6     <= asr(({16'b0, ah5} << 14) - (coef.h4 << 20) - h5v5 + K_16384, 15);
      y1_6   <= asr(vh6_5, 10) * (asr(vh3_5, 11) + K_32768);

      fl7 <= fl6; ap7 <= ap6; tp7 <= tp6;
      v2_7 <= asr(v2a6 + (v1p5_6 << 1), 2) + (coef.p4 << 16);
      v1b7 <= asr(asr(c6, 3) + asr(p2v1_6, 1), 18);
      y2_7 <= (asr(y1_6, 10) + K_2097152) * coef.h2;
      x7   <= x6;

      fl8 <= fl7; tp8 <= tp7;
      v1c8 <= (K_32768 + v1b7) * coef.p1;
      pnp8 <= (K_1048576 - {12'b0, ap7}) - asr(v2_7, 12);
      y8   <= asr(y2_7 + K_8192, 14);
      x8   <= x7;

      fl9 <= fl8; tp9 <= tp8;
      v1d9 <= asr(v1c8, 15);
      pn9  <= pnp8 * K_3125;
      hx9  <= x8 * y8;

      // after the divider
      tg1 <= dout_side.tag;
      pd1 <= dout_side.shf ? (quo << 1) : quo;
      s1h <= asr(dout_side.hx, 15);
      hx1 <= dout_side.hx;

      tg2 <= tg1; pd2 <= pd1; hx2 <= hx1;
      pp2   <= ((pd1 >> 3) * (pd1 >> 3)) >> 13;
      pv8_2 <= (pd1 >> 2) * coef.p8;
      ss2   <= s1h * s1h;

      tg3 <= tg2; pd3 <= pd2; hx3 <= hx2;
      pv1_3 <= asr(coef.p9 * pp2, 12);
      pv2_3 <= asr(pv8_2, 13);
      ht3   <= asr(ss2, 7) * coef.h1;

      tg4 <= tg3;
      pf4 <= pd3 + asr(pv1_3 + pv2_3 + coef.p7, 4);
      hc4 <= hcl;

      tg5 <= tg4; pf5 <= pf4;
      m5  <= pf4 * K_1000;
      hm5 <= hmul[19:10];

      tg6 <= tg5; pf6 <= pf5; hm6 <= hm5; m6 <= m5;
      prod6 <= {32'b0, m5} * {32'b0, MM_RECIP};

      tg7 <= tg6; pf7 <= pf6; hm7 <= hm6; m7 <= m6;
      q7 <= prod6[63:45];

      tg8 <= tg7; pf8 <= pf7; hm8 <= hm7;
      q8 <= q7;
      r8 <= m7 - ({13'b0, q7} * MM_DIV);

      // output register
      temperature_valid <= tg8.tv;
      temperature_c100  <= tg8.tv ? tg8.temp : '0;
      pressure_valid    <= tg8.pv;
      pressure_pa       <= pok ? pf8 : '0;
      pressure_mmhg10   <= pok ? ({13'b0, q8} + {31'b0, (r8 >= MM_DIV)}) : '0;
      humidity_valid    <= tg8.hv;
      humidity_h10      <= tg8.hv ? hm8 : '0;
    end
  end

endmodule

FILE: rtl/core/barometric_sensor_compensation.sv
// Top level of the barometric sensor compensation block.
// One reading set is taken per clock and one result beat leaves per clock while
// out_ready is high. From input acceptance to out_valid a beat passes the input
// register, the queue, nine stages of temperature and pressure/humidity products,
// a 32-stage one-bit-per-stage divider, eight stages of pressure refinement and
// mmHg scaling, and the output register. Queued beats and output stalls delay it further.
// The whole datapath is pipelined, so throughput is set by the single beat per
// cycle of that pipeline. Calibration registers are to be written by the user
// through the cfg port while no reading is in flight; the block does not enforce it.
module barometric_sensor_compensation import bsc_pkg::*; #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [19:0]           raw_temperature,
  input  logic [19:0]           raw_pressure,
  input  logic [15:0]           raw_humidity,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [15:0]           temperature_c100,
  output logic                  temperature_valid,
  output logic [31:0]           pressure_pa,
  output logic [31:0]           pressure_mmhg10,
  output logic                  pressure_valid,
  output logic [9:0]            humidity_h10,
  output logic                  humidity_valid
);

  logic [47:0] temp_coeffs;
  logic [63:0] press_coeffs_low;
  logic [63:0] press_coeffs_high;
  logic [55:0] press_hum_coeffs;
  logic [23:0] hum_offset_coeffs;
  logic        humidity_present;

  coef_t coef;
  item_t fitem, q_item;
  logic  fv, full, push_ok, q_valid, pop;

  always_ff @(posedge clk) begin
    if (rst) begin
      temp_coeffs       <= '0;
      press_coeffs_low  <= '0;
      press_coeffs_high <= '0;
      press_hum_coeffs  <= '0;
      hum_offset_coeffs <= '0;
      humidity_present  <= 1'b0;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        REG_TEMP:      temp_coeffs       <= cfg_wdata[47:0];
        REG_PRESS_LO:  press_coeffs_low  <= cfg_wdata;
        REG_PRESS_HI:  press_coeffs_high <= cfg_wdata;
        REG_PRESS_HUM: press_hum_coeffs  <= cfg_wdata[55:0];
        REG_HUM_OFS:   hum_offset_coeffs <= cfg_wdata[23:0];
        REG_HUM_EN:    humidity_present  <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  assign coef.t1 = {16'b0, temp_coeffs[15:0]};
  assign coef.t2 = {{16{temp_coeffs[31]}}, temp_coeffs[31:16]};
  assign coef.t3 = {{16{temp_coeffs[47]}}, temp_coeffs[47:32]};
  assign coef.p1 = {16'b0, press_coeffs_low[15:0]};
  assign coef.p2 = {{16{press_coeffs_low[31]}}, press_coeffs_low[31:16]};
  assign coef.p3 = {{16{press_coeffs_low[47]}}, press_coeffs_low[47:32]};
  assign coef.p4 = {{16{press_coeffs_low[63]}}, press_coeffs_low[63:48]};
  assign coef.p5 = {{16{press_coeffs_high[15]}}, press_coeffs_high[15:0]};
  assign coef.p6 = {{16{press_coeffs_high[31]}}, press_coeffs_high[31:16]};
  assign coef.p7 = {{16{press_coeffs_high[47]}}, press_coeffs_high[47:32]};
  assign coef.p8 = {{16{press_coeffs_high[63]}}, press_coeffs_high[63:48]};
  assign coef.p9 = {{16{press_hum_coeffs[15]}}, press_hum_coeffs[15:0]};
  assign coef.h1 = {24'b0, press_hum_coeffs[23:16]};
  assign coef.h2 = {{16{press_hum_coeffs[39]}}, press_hum_coeffs[39:24]};
  assign coef.h3 = {24'b0, press_hum_coeffs[47:40]};
  assign coef.h6 = {{24{press_hum_coeffs[55]}}, press_hum_coeffs[55:48]};
  assign coef.h4 = {{20{hum_offset_coeffs[11]}}, hum_offset_coeffs[11:0]};
  assign coef.h5 = {{20{hum_offset_coeffs[23]}}, hum_offset_coeffs[23:12]};
  assign coef.hum_en = humidity_present;

  assign push_ok = !full;

  bsc_front u_front (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .raw_temperature (raw_temperature),
    .raw_pressure    (raw_pressure),
    .raw_humidity    (raw_humidity),
    .coef            (coef),
    .push_ok         (push_ok),
    .fv              (fv),
    .fitem           (fitem)
  );

  bsc_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (fv && push_ok),
    .push_item (fitem),
    .full      (full),
    .pop       (pop),
    .q_valid   (q_valid),
    .q_item    (q_item)
  );

  bsc_back u_back (
    .clk               (clk),
    .rst               (rst),
    .coef              (coef),
    .q_valid           (q_valid),
    .q_item            (q_item),
    .pop               (pop),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .temperature_c100  (temperature_c100),
    .temperature_valid (temperature_valid),
    .pressure_pa       (pressure_pa),
    .pressure_mmhg10   (pressure_mmhg10),
    .pressure_valid    (pressure_valid),
    .humidity_h10      (humidity_h10),
    .humidity_valid    (humidity_valid)
  );

`ifndef SYNTHESIS
  a_tdis_clears: assert property (@(posedge clk) disable iff (rst)
    out_valid && !temperature_valid |->
      !pressure_valid && !humidity_valid && pressure_pa == '0 && temperature_c100 == '0)
    else $error("disabled temperature leaked into result");

  a_hum_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> humidity_h10 <= 10'd1000)
    else $error("humidity above full scale");

  a_pdis_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !pressure_valid |-> pressure_mmhg10 == '0 && pressure_pa == '0)
    else $error("disabled pressure not zeroed");

  a_queue_flow: assert property (@(posedge clk) disable iff (rst)
    full |-> !in_ready || !fv)
    else $error("front accepted while queue full and holding a beat");
`endif

endmodule
